### hw/rtl/lzwd_pkg.sv
// shared types and constants of the lzss window decompressor
package lzwd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned DistW     = 12;
  localparam int unsigned LenCodeW  = 4;
  localparam int unsigned FlagCntW  = 4;
  localparam int unsigned CopyIdxW  = 5;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [FlagCntW-1:0] FlagsPerTag = FlagCntW'(8);
  localparam logic [CopyIdxW-1:0] LenBias     = CopyIdxW'(2);
  localparam logic [ByteW-1:0]    EndMarker   = '0;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_ITEM,
    PH_DIST,
    PH_END
  } phase_e;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [ByteW-1:0]      data;
    logic [LenCodeW-1:0]   len_code;
    logic [DistW-1:0]      distance;
  } cmd_t;

endpackage

### hw/rtl/lzwd_if.sv
// request channels of the lzss window decompressor
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic       stream_end;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output stream_end, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input last,
                input stream_end, output ready);
endinterface

### hw/rtl/lzwd_front.sv
// stream parser: tag flags, literals, match control and end marker
module lzwd_front
  import lzwd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      hold_i,
  lzwd_in_if.sink   in_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output cmd_t      q_cmd_o
);

  phase_e               phase_q, phase_d;
  logic [ByteW-1:0]     flag_bits_q, flag_bits_d;
  logic [FlagCntW-1:0]  flags_left_q, flags_left_d;
  logic [ByteW-1:0]     held_q, held_d;
  logic                 accept;
  logic [ByteW-1:0]     b;
  logic [FlagCntW-1:0]  left_dec;

  assign in_i.ready = !hold_i && !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign left_dec   = flags_left_q - FlagCntW'(1);

  // next state
  always_comb begin
    phase_d      = phase_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    held_d       = held_q;
    if (accept) begin
      unique case (phase_q)
        PH_TAG: begin
          flag_bits_d  = b;
          flags_left_d = FlagsPerTag;
          phase_d      = PH_ITEM;
        end
        PH_ITEM: begin
          flag_bits_d  = {flag_bits_q[ByteW-2:0], 1'b0};
          flags_left_d = left_dec;
          if (!flag_bits_q[ByteW-1]) begin
            phase_d = (left_dec == '0) ? PH_TAG : PH_ITEM;
          end else if (b == EndMarker) begin
            phase_d = PH_END;
          end else begin
            held_d  = b;
            phase_d = PH_DIST;
          end
        end
        PH_DIST: begin
          phase_d = (flags_left_q == '0) ? PH_TAG : PH_ITEM;
        end
        PH_END: begin
          phase_d = PH_END;
        end
        default: phase_d = PH_TAG;
      endcase
    end
  end

  // command to the back end
  always_comb begin
    q_push_o          = 1'b0;
    q_cmd_o.kind      = CMD_LIT;
    q_cmd_o.data      = b;
    q_cmd_o.len_code  = held_q[LenCodeW-1:0];
    q_cmd_o.distance  = {held_q[ByteW-1:LenCodeW], b};
    unique case (phase_q)
      PH_ITEM: begin
        q_push_o = accept && (!flag_bits_q[ByteW-1] || b == EndMarker);
        if (flag_bits_q[ByteW-1]) q_cmd_o.kind = CMD_END;
      end
      PH_DIST: begin
        q_push_o     = accept;
        q_cmd_o.kind = CMD_COPY;
      end
      PH_TAG, PH_END: q_push_o = 1'b0;
      default: q_push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TAG;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      held_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      held_q       <= held_d;
    end
  end

endmodule

### hw/rtl/lzwd_queue.sv
// short command queue between parser and copy engine
module lzwd_queue
  import lzwd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  output logic  full_o,
  output logic  valid_o,
  output cmd_t  head_o,
  input  logic  pop_i
);

  cmd_t                  entry_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QueuePtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QueueCntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - QueueCntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### hw/rtl/lzwd_back.sv
// copy engine: history memory, byte issue, write back and output register
module lzwd_back
  import lzwd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  output logic       clearing_o,
  input  logic       q_valid_i,
  input  cmd_t       q_head_i,
  output logic       q_pop_o,
  lzwd_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);

  logic [ByteW-1:0]     mem [HISTORY_DEPTH];
  logic [ByteW-1:0]     rdata_q;

  logic                 clr_q;
  logic [AddrW-1:0]     clr_addr_q;
  logic [AddrW-1:0]     ip_q;
  logic [AddrW-1:0]     wp_q;
  logic [CopyIdxW-1:0]  idx_q;
  logic [ByteW-1:0]     last_wr_q;

  logic                 s2_valid_q;
  cmd_kind_e            s2_kind_q;
  logic [ByteW-1:0]     s2_lit_q;
  logic                 s2_fwd_q;
  logic                 s2_last_q;

  logic                 out_valid_q;
  logic [ByteW-1:0]     out_byte_q;
  logic                 out_bvalid_q;
  logic                 out_last_q;
  logic                 out_end_q;

  logic                 s2_adv, s2_free, issue, is_copy, cmd_last, rd_en, we;
  logic [CopyIdxW-1:0]  len_m1;
  logic [AddrW-1:0]     raddr, waddr;
  logic [ByteW-1:0]     s2_data, wdata;

  assign clearing_o = clr_q;

  // byte issue from the queue head
  assign is_copy  = (q_head_i.kind == CMD_COPY);
  assign len_m1   = CopyIdxW'(q_head_i.len_code) + LenBias - CopyIdxW'(1);
  assign cmd_last = !is_copy || (idx_q == len_m1);
  assign s2_adv   = s2_valid_q && (!out_valid_q || out_o.ready);
  assign s2_free  = !s2_valid_q || s2_adv;
  assign issue    = q_valid_i && s2_free && !clr_q;
  assign q_pop_o  = issue && cmd_last;
  assign rd_en    = issue && is_copy;
  assign raddr    = ip_q - AddrW'(q_head_i.distance);

  // distance one reads the byte written in the same cycle
  assign s2_data = (s2_kind_q == CMD_LIT) ? s2_lit_q :
                   (s2_fwd_q ? last_wr_q : rdata_q);

  assign we    = clr_q || (s2_adv && s2_kind_q != CMD_END);
  assign waddr = clr_q ? clr_addr_q : wp_q;
  assign wdata = clr_q ? '0 : s2_data;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == '1) clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q       <= '0;
      idx_q      <= '0;
      s2_valid_q <= 1'b0;
      s2_kind_q  <= CMD_LIT;
    end else begin
      if (issue) begin
        idx_q      <= cmd_last ? '0 : idx_q + CopyIdxW'(1);
        if (q_head_i.kind != CMD_END) ip_q <= ip_q + AddrW'(1);
        s2_valid_q <= 1'b1;
        s2_kind_q  <= q_head_i.kind;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_lit_q  <= q_head_i.data;
      s2_fwd_q  <= (q_head_i.distance == DistW'(1));
      s2_last_q <= cmd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      last_wr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_adv) begin
        out_valid_q <= 1'b1;
        if (s2_kind_q != CMD_END) begin
          wp_q      <= wp_q + AddrW'(1);
          last_wr_q <= s2_data;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_byte_q   <= (s2_kind_q == CMD_END) ? '0 : s2_data;
      out_bvalid_q <= (s2_kind_q != CMD_END);
      out_last_q   <= s2_last_q;
      out_end_q    <= (s2_kind_q == CMD_END);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.byte_valid = out_bvalid_q;
  assign out_o.last       = out_last_q;
  assign out_o.stream_end = out_end_q;

endmodule

### hw/rtl/lzss_window_decompressor_unit.sv
// top level of the lzss window decompressor
// Decodes an lzss stream one compressed byte per request and delivers at most one
// decompressed byte per result at up to one result per cycle. The copy engine
// issues one byte a cycle, while the output is not stalled, from a history
// memory with one read and one write port; it sets the rate on long matches.
// Tag, control and distance bytes are each parsed as they are taken; literals,
// end markers and complete matches are queued, so the parser keeps taking input
// while a copy is in progress, until the queue is full. After reset the history
// (4096 bytes by default) is cleared, one entry a cycle; no input is accepted
// during that pass. After the end marker, input is taken and dropped until reset.
module lzss_window_decompressor_unit
  import lzwd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzwd_in_if.sink     in_i,
  lzwd_out_if.source  out_o
);

  logic  clearing;
  logic  q_push, q_full, q_valid, q_pop;
  cmd_t  q_cmd, q_head;

  lzwd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .hold_i   (clearing),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd)
  );

  lzwd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  lzwd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clearing_o (clearing),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_o      (out_o)
  );

endmodule
